[hw/rtl/ssd_template_match_assert.svh]
// Assertion macros used by the template matcher search engine.
`ifndef SSD_TEMPLATE_MATCH_ASSERT_SVH
`define SSD_TEMPLATE_MATCH_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/ssd_pkg.sv]
// Shared types and constants of the template matcher.
`timescale 1ns / 1ps
package ssd_pkg;
    localparam int MaxIw = 256;
    localparam int MaxIh = 256;
    localparam int MaxTw = 32;
    localparam int MaxTh = 32;
    localparam int ImgAw = 16;
    localparam int TplAw = 10;
    localparam int ImgCntW = 17;
    localparam int TplCntW = 11;
    localparam logic OP_TEMPLATE = 1'b0;
    localparam logic OP_IMAGE = 1'b1;
    localparam logic [1:0] REG_IW = 2'd0;
    localparam logic [1:0] REG_IH = 2'd1;
    localparam logic [1:0] REG_TW = 2'd2;
    localparam logic [1:0] REG_TH = 2'd3;

    // Command passed from the front end to the search engine.
    typedef struct packed {
        logic       err;
        logic [8:0] iw;
        logic [8:0] ih;
        logic [5:0] tw;
        logic [5:0] th;
    } cmd_t;

    // Result item.
    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [25:0] score;
        logic        status;
    } res_t;
endpackage

[hw/rtl/ssd_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ssd_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/ssd_front.sv]
// Front end: accepts pixels, writes the stores and issues search commands.
`timescale 1ns / 1ps
module ssd_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [7:0]               pixel,
    input  logic [8:0]               iw,
    input  logic [8:0]               ih,
    input  logic [5:0]               tw,
    input  logic [5:0]               th,
    output logic                     img_we,
    output logic [ssd_pkg::ImgAw-1:0] img_waddr,
    output logic                     tpl_we,
    output logic [ssd_pkg::TplAw-1:0] tpl_waddr,
    output logic [7:0]               wdata,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output ssd_pkg::cmd_t            cmd
);
    logic [ssd_pkg::ImgCntW-1:0] img_cnt_reg, img_cnt_next;
    logic [ssd_pkg::TplCntW-1:0] tpl_cnt_reg, tpl_cnt_next;
    logic                        cmd_valid_reg;
    ssd_pkg::cmd_t               cmd_reg;
    logic                        acc, frame_end;
    logic [16:0]                 img_total;
    logic [10:0]                 tpl_total;

    assign acc = in_valid && in_ready;
    // The stores must hold still while the engine reads them, so input waits
    // for an idle engine and an empty command slot.
    assign in_ready = !cmd_valid_reg && cmd_ready;
    assign img_total = 17'(iw) * 17'(ih);
    assign tpl_total = 11'(tw) * 11'(th);
    assign img_cnt_next = img_cnt_reg + 17'd1;
    assign tpl_cnt_next = tpl_cnt_reg + 11'd1;
    assign frame_end = acc && opcode == ssd_pkg::OP_IMAGE && img_cnt_next >= img_total;

    // Store write ports.
    assign img_we = acc && opcode == ssd_pkg::OP_IMAGE && !img_cnt_reg[16];
    assign img_waddr = img_cnt_reg[ssd_pkg::ImgAw-1:0];
    assign tpl_we = acc && opcode == ssd_pkg::OP_TEMPLATE && !tpl_cnt_reg[10];
    assign tpl_waddr = tpl_cnt_reg[ssd_pkg::TplAw-1:0];
    assign wdata = pixel;
    assign cmd_valid = cmd_valid_reg;
    assign cmd = cmd_reg;

    // Load counters and the command slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_cnt_reg <= '0;
            tpl_cnt_reg <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc && opcode == ssd_pkg::OP_TEMPLATE)
            begin
                tpl_cnt_reg <= (tpl_cnt_next >= tpl_total) ? '0 : tpl_cnt_next;
            end
            if (acc && opcode == ssd_pkg::OP_IMAGE)
            begin
                img_cnt_reg <= frame_end ? '0 : img_cnt_next;
            end
            if (frame_end)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (cmd_ready)
            begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    // Command payload captured at frame end.
    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            cmd_reg.err <= (9'(tw) > iw) || (9'(th) > ih);
            cmd_reg.iw <= iw;
            cmd_reg.ih <= ih;
            cmd_reg.tw <= tw;
            cmd_reg.th <= th;
        end
    end
endmodule

[hw/rtl/ssd_engine.sv]
// Search engine: scores every placement one pixel pair per cycle.
`timescale 1ns / 1ps
`include "ssd_template_match_assert.svh"
module ssd_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  ssd_pkg::cmd_t             cmd,
    output logic [ssd_pkg::ImgAw-1:0] img_raddr,
    input  logic [7:0]                img_rdata,
    output logic [ssd_pkg::TplAw-1:0] tpl_raddr,
    input  logic [7:0]                tpl_rdata,
    output logic                      res_valid,
    input  logic                      res_ready,
    output ssd_pkg::res_t             res
);
    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE, S_OUT} state_t;
    state_t        state_reg;
    ssd_pkg::cmd_t c_reg;
    logic [7:0]    px_reg, py_reg;
    logic [4:0]    tx_reg, ty_reg;
    logic [15:0]   base_reg, row_reg;
    logic [9:0]    toff_reg;
    logic          v1_reg, v2_reg, v3_reg, last1_reg, last2_reg, last3_reg;
    logic          v4_reg;
    logic [7:0]    px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic [8:0]    diff_reg;
    logic [15:0]   sq_reg;
    logic [25:0]   acc_reg;
    logic [26:0]   best_reg;
    logic [7:0]    bx_reg, by_reg;
    logic [25:0]   sum_fin_reg;
    logic [7:0]    fx_reg, fy_reg;
    ssd_pkg::res_t res_reg;
    logic          res_valid_reg;
    logic          last_tx, last_ty, last_px, last_py, issue;
    logic [8:0]    a9, b9, d9;
    logic [25:0]   acc_sum;

    assign cmd_ready = state_reg == S_IDLE;
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign img_raddr = base_reg + row_reg + 16'(tx_reg);
    assign tpl_raddr = toff_reg + 10'(tx_reg);
    assign issue = state_reg == S_RUN;
    assign last_tx = 6'(tx_reg) + 6'd1 == c_reg.tw;
    assign last_ty = 6'(ty_reg) + 6'd1 == c_reg.th;
    assign last_px = 9'(px_reg) + 9'(c_reg.tw) == c_reg.iw;
    assign last_py = 9'(py_reg) + 9'(c_reg.th) == c_reg.ih;
    assign a9 = {1'b0, img_rdata};
    assign b9 = {1'b0, tpl_rdata};
    assign d9 = (a9 > b9) ? a9 - b9 : b9 - a9;
    assign acc_sum = acc_reg + 26'(sq_reg);

    // Scan sequencer, pipeline and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            best_reg <= '1;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && last3_reg;
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg <= cmd;
                        px_reg <= '0;
                        py_reg <= '0;
                        tx_reg <= '0;
                        ty_reg <= '0;
                        base_reg <= '0;
                        row_reg <= '0;
                        toff_reg <= '0;
                        if (cmd.err)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            best_reg <= '1;
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (!last_tx)
                    begin
                        tx_reg <= tx_reg + 5'd1;
                    end
                    else
                    begin
                        tx_reg <= '0;
                        if (!last_ty)
                        begin
                            ty_reg <= ty_reg + 5'd1;
                            row_reg <= row_reg + 16'(c_reg.iw);
                            toff_reg <= toff_reg + 10'(c_reg.tw);
                        end
                        else
                        begin
                            ty_reg <= '0;
                            row_reg <= '0;
                            toff_reg <= '0;
                            if (!last_px)
                            begin
                                px_reg <= px_reg + 8'd1;
                                base_reg <= base_reg + 16'd1;
                            end
                            else
                            begin
                                px_reg <= '0;
                                py_reg <= py_reg + 8'd1;
                                base_reg <= base_reg + 16'd1 + 16'(c_reg.tw) - 16'd1
                                    + 16'(c_reg.iw) - 16'(c_reg.iw - 9'(c_reg.tw))
                                    - 16'(c_reg.tw);
                                if (last_py)
                                begin
                                    state_reg <= S_DRAIN;
                                end
                            end
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // The result register is only loaded once the previous item has left.
                    if (!res_valid_reg)
                    begin
                        if (c_reg.err)
                        begin
                            res_reg <= '{x: 8'd0, y: 8'd0, score: 26'd0, status: 1'b1};
                        end
                        else
                        begin
                            res_reg <= '{x: bx_reg, y: by_reg, score: best_reg[25:0],
                                         status: 1'b0};
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // Compare a finished placement sum against the best so far.
            if (v4_reg && {1'b0, sum_fin_reg} < best_reg)
            begin
                best_reg <= {1'b0, sum_fin_reg};
                bx_reg <= fx_reg;
                by_reg <= fy_reg;
            end
        end
    end

    // Datapath: read, difference, square, accumulate.
    always_ff @(posedge clk)
    begin
        last1_reg <= last_tx && last_ty;
        px1_reg <= px_reg;
        py1_reg <= py_reg;
        last2_reg <= last1_reg;
        px2_reg <= px1_reg;
        py2_reg <= py1_reg;
        diff_reg <= d9;
        last3_reg <= last2_reg;
        px3_reg <= px2_reg;
        py3_reg <= py2_reg;
        sq_reg <= 16'(diff_reg) * 16'(diff_reg);
        if (v3_reg)
        begin
            acc_reg <= last3_reg ? '0 : acc_sum;
            if (last3_reg)
            begin
                sum_fin_reg <= acc_sum;
                fx_reg <= px3_reg;
                fy_reg <= py3_reg;
            end
        end
        else if (state_reg == S_IDLE)
        begin
            acc_reg <= '0;
        end
    end

    `SSD_ASSERT_IMP(a_ready_idle, clk, rst_n, cmd_ready, state_reg == S_IDLE)
    `SSD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)
    `SSD_ASSERT_IMP(a_no_issue_idle, clk, rst_n, state_reg == S_IDLE, !v1_reg || !issue)
endmodule

[hw/rtl/ssd_template_match.sv]
// Top level of the sum-of-squared-differences template matcher.
`timescale 1ns / 1ps
// Channel   Signals                                    Direction
// in        in_valid/in_ready, opcode, pixel           into block
// out       out_valid/out_ready, best_x/y/score, status out of block
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data   into block
// Loading takes one pixel item per cycle into the image and template RAMs.
// After the last image pixel is accepted, the engine reads one pixel pair per cycle;
// the result is presented once every placement has been scored.
// Input stalls while the engine searches and while a finished frame waits in the
// command slot, so the stores never change under a search.
// Reset clears counters and control; RAM contents are undefined until loaded.
module ssd_template_match (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  best_x,
    output logic [7:0]  best_y,
    output logic [25:0] best_score,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    logic [8:0] iw_reg, ih_reg;
    logic [5:0] tw_reg, th_reg;
    logic [8:0] iw, ih;
    logic [5:0] tw, th;
    logic img_we, tpl_we, cmd_valid, cmd_ready;
    logic [ssd_pkg::ImgAw-1:0] img_waddr, img_raddr;
    logic [ssd_pkg::TplAw-1:0] tpl_waddr, tpl_raddr;
    logic [7:0] wdata, img_rdata, tpl_rdata;
    ssd_pkg::cmd_t cmd;
    ssd_pkg::res_t res;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= 9'(ssd_pkg::MaxIw);
            ih_reg <= 9'(ssd_pkg::MaxIh);
            tw_reg <= 6'(ssd_pkg::MaxTw);
            th_reg <= 6'(ssd_pkg::MaxTh);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ssd_pkg::REG_IW: iw_reg <= cfg_data;
                ssd_pkg::REG_IH: ih_reg <= cfg_data;
                ssd_pkg::REG_TW: tw_reg <= cfg_data[5:0];
                ssd_pkg::REG_TH: th_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clamp dimensions into their legal ranges.
    assign iw = (iw_reg == 0) ? 9'd1 : (iw_reg > 9'(ssd_pkg::MaxIw)) ? 9'(ssd_pkg::MaxIw) : iw_reg;
    assign ih = (ih_reg == 0) ? 9'd1 : (ih_reg > 9'(ssd_pkg::MaxIh)) ? 9'(ssd_pkg::MaxIh) : ih_reg;
    assign tw = (tw_reg == 0) ? 6'd1 : (tw_reg > 6'(ssd_pkg::MaxTw)) ? 6'(ssd_pkg::MaxTw) : tw_reg;
    assign th = (th_reg == 0) ? 6'd1 : (th_reg > 6'(ssd_pkg::MaxTh)) ? 6'(ssd_pkg::MaxTh) : th_reg;

    ssd_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .opcode, .pixel,
        .iw, .ih, .tw, .th, .img_we, .img_waddr, .tpl_we, .tpl_waddr, .wdata,
        .cmd_valid, .cmd_ready, .cmd
    );

    ssd_ram #(.Width(8), .Depth(1 << ssd_pkg::ImgAw)) u_img (
        .clk, .we(img_we), .waddr(img_waddr), .wdata, .raddr(img_raddr), .rdata(img_rdata)
    );

    ssd_ram #(.Width(8), .Depth(1 << ssd_pkg::TplAw)) u_tpl (
        .clk, .we(tpl_we), .waddr(tpl_waddr), .wdata, .raddr(tpl_raddr), .rdata(tpl_rdata)
    );

    ssd_engine u_engine (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .img_raddr, .img_rdata,
        .tpl_raddr, .tpl_rdata, .res_valid(out_valid), .res_ready(out_ready), .res
    );

    assign best_x = res.x;
    assign best_y = res.y;
    assign best_score = res.score;
    assign status = res.status;
endmodule
